// ===== hw/rtl/jmd_pkg.sv =====
package jmd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER    = 3'd0,
        CFG_DEAD_BAND = 3'd1,
        CFG_LONG_MS   = 3'd2,
        CFG_WINDOW_MS = 3'd3,
        CFG_DIV_ONE   = 3'd4,
        CFG_DIV_TWO   = 3'd5,
        CFG_DIV_THREE = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [11:0] RST_CENTER    = 12'd2048;
    localparam logic [9:0]  RST_DEAD_BAND = 10'd100;
    localparam logic [15:0] RST_LONG_MS   = 16'd1000;
    localparam logic [15:0] RST_WINDOW_MS = 16'd500;
    localparam logic [7:0]  RST_DIV_ONE   = 8'd5;
    localparam logic [7:0]  RST_DIV_TWO   = 8'd10;
    localparam logic [7:0]  RST_DIV_THREE = 8'd30;

    // Sensitivity levels
    localparam logic [1:0] LEVEL_ONE   = 2'd1;
    localparam logic [1:0] LEVEL_TWO   = 2'd2;
    localparam logic [1:0] LEVEL_THREE = 2'd3;

    // Axis scaling
    localparam logic [6:0] AXIS_MAX = 7'd127;

    // Shared divider: dividend register width, steps per clock, cycle counts
    localparam int W_Q       = 20;
    localparam int DIV_STEPS = 2;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] MAP_DIV_CYC = CNT_W'(W_Q / DIV_STEPS);
    localparam logic [CNT_W-1:0] SCL_DIV_CYC = CNT_W'(8 / DIV_STEPS);

    // Divide operations of one poll
    typedef enum logic [1:0] {
        OP_MAPX = 2'd0,
        OP_MAPY = 2'd1,
        OP_SCLX = 2'd2,
        OP_SCLY = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic decide;
        logic div_start;
        t_op  start_op;
        logic store;
        t_op  store_op;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_cmd;
        logic blocked;
        logic div_done;
        logic has_result;
        logic out_busy;
    } t_stat;

endpackage

// ===== hw/rtl/joystick_to_mouse_delta.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------------
// input    | in        | i_in_valid / o_in_ready | i_action i_time_ms i_raw_x i_raw_y
//          |           |                         | i_button_down
// result   | out       | o_out_valid/i_out_ready | o_left_click o_move_x o_move_y o_level_now
// config   | in        | i_cfg_we (no wait)      | i_cfg_idx i_cfg_data
//
// A joystick poll runs from input transfer to result load through decide, four divides on
// one shared two-bit-per-clock divider (X and Y axis mapping, then X and Y sensitivity
// scaling, each result stored as the next divide starts) and finish; the next input
// transfer can follow in the cycle after the result load.
// Host commands and blocked polls end after the decide step.
// Reset is synchronous, active low; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken; the
// controller stalls only when a new result is ready and that register is still full.
module joystick_to_mouse_delta #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [jmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [31:0]                    i_time_ms,
    input  logic [11:0]                    i_raw_x,
    input  logic [11:0]                    i_raw_y,
    input  logic                           i_button_down,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_left_click,
    output logic signed [7:0]              o_move_x,
    output logic signed [7:0]              o_move_y,
    output logic [1:0]                     o_level_now
);
    import jmd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    jmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Registers, state and shared divider
    jmd_dpath #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_time_ms     (i_time_ms),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_button_down (i_button_down),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_left_click  (o_left_click),
        .o_move_x      (o_move_x),
        .o_move_y      (o_move_y),
        .o_level_now   (o_level_now),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

// ===== hw/rtl/jmd_div.sv =====
module jmd_div #(
    parameter int W_D = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [jmd_pkg::W_Q-1:0]   i_dividend,
    input  logic [W_D-1:0]            i_divisor,
    input  logic [jmd_pkg::CNT_W-1:0] i_cycles,
    output logic                      o_done,
    output logic [jmd_pkg::W_Q-1:0]   o_quot
);
    import jmd_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W_D-1:0]   r_den;
    logic [W_D-1:0]   r_rem;
    logic [W_Q-1:0]   r_quo;
    logic [W_D-1:0]   n_rem;
    logic [W_Q-1:0]   n_quo;
    logic [W_D-1:0]   rem;
    logic [W_Q-1:0]   quo;
    logic [W_D:0]     sh;

    // Restoring division, DIV_STEPS quotient bits per clock
    always_comb begin
        rem = r_rem;
        quo = r_quo;
        sh  = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh  = {rem, quo[W_Q-1]};
            quo = {quo[W_Q-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh     = sh - {1'b0, r_den};
                quo[0] = 1'b1;
            end
            rem = sh[W_D-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_cycles;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/jmd_dpath.sv =====
module jmd_dpath #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [jmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input payload
    input  logic                           i_action,
    input  logic [31:0]                    i_time_ms,
    input  logic [11:0]                    i_raw_x,
    input  logic [11:0]                    i_raw_y,
    input  logic                           i_button_down,
    // result channel
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_left_click,
    output logic signed [7:0]              o_move_x,
    output logic signed [7:0]              o_move_y,
    output logic [1:0]                     o_level_now,
    // controller link
    input  jmd_pkg::t_cmd                  i_cmd,
    output jmd_pkg::t_stat                 o_stat
);
    import jmd_pkg::*;

    localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
    localparam int W_D  = (FS_W > 12) ? FS_W : 12;
    localparam int W_S  = W_D + 2;

    // Configuration registers
    logic [11:0] r_center;
    logic [9:0]  r_dead;
    logic [15:0] r_long;
    logic [15:0] r_window;
    logic [7:0]  r_div1;
    logic [7:0]  r_div2;
    logic [7:0]  r_div3;

    // Captured poll
    logic        r_action;
    logic [31:0] r_time;
    logic [11:0] r_raw_x;
    logic [11:0] r_raw_y;
    logic        r_btn;

    // Persistent state
    logic [31:0] r_cmd_time;
    logic [1:0]  r_level;
    logic        r_prev_btn;
    logic [31:0] r_press_start;
    logic        r_stepped;

    // Intermediate results
    logic [6:0]  r_jx_mag;
    logic        r_jx_neg;
    logic [6:0]  r_jy_mag;
    logic        r_jy_neg;
    logic [6:0]  r_mx_mag;
    logic [6:0]  r_my_mag;

    // Output register
    logic        r_out_valid;
    logic        r_out_click;
    logic [7:0]  r_out_x;
    logic [7:0]  r_out_y;
    logic [1:0]  r_out_level;

    logic                 blocked;
    logic                 long_held;
    logic [11:0]          raw;
    logic [12:0]          s_hi;
    logic signed [13:0]   lo;
    logic signed [W_S-1:0] den_hi;
    logic                 den_hi_ok;
    logic [11:0]          mag;
    logic                 map_neg;
    logic                 map_ok;
    logic [W_D-1:0]       map_den;
    logic [18:0]          prod;
    logic [7:0]           lvl_div;
    logic [W_Q-1:0]       dividend;
    logic [W_D-1:0]       divisor;
    logic [CNT_W-1:0]     cycles;
    logic                 div_done;
    logic [W_Q-1:0]       quot;
    logic [6:0]           quot_sat;
    logic                 has_motion;
    logic                 has_click;
    logic [7:0]           mx;
    logic [7:0]           my;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= RST_CENTER;
            r_dead   <= RST_DEAD_BAND;
            r_long   <= RST_LONG_MS;
            r_window <= RST_WINDOW_MS;
            r_div1   <= RST_DIV_ONE;
            r_div2   <= RST_DIV_TWO;
            r_div3   <= RST_DIV_THREE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER:    r_center <= i_cfg_data[11:0];
                CFG_DEAD_BAND: r_dead   <= i_cfg_data[9:0];
                CFG_LONG_MS:   r_long   <= i_cfg_data;
                CFG_WINDOW_MS: r_window <= i_cfg_data;
                CFG_DIV_ONE:   r_div1   <= i_cfg_data[7:0];
                CFG_DIV_TWO:   r_div2   <= i_cfg_data[7:0];
                CFG_DIV_THREE: r_div3   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_time   <= i_time_ms;
            r_raw_x  <= i_raw_x;
            r_raw_y  <= i_raw_y;
            r_btn    <= i_button_down;
        end
    end

    // Wrapping time compares
    assign blocked   = (r_time - r_cmd_time) < {16'd0, r_window};
    assign long_held = (r_time - r_press_start) >= {16'd0, r_long};

    // Command time, button tracking and level stepping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_time    <= '0;
            r_level       <= LEVEL_TWO;
            r_prev_btn    <= 1'b0;
            r_press_start <= '0;
            r_stepped     <= 1'b0;
        end else if (i_cmd.decide) begin
            if (r_action) begin
                r_cmd_time <= r_time;
            end else if (!blocked) begin
                if (r_btn && !r_prev_btn) begin
                    r_press_start <= r_time;
                    r_stepped     <= 1'b0;
                end else if (r_btn && !r_stepped && long_held) begin
                    r_level   <= (r_level == LEVEL_THREE) ? LEVEL_ONE : r_level + 2'd1;
                    r_stepped <= 1'b1;
                end
                r_prev_btn <= r_btn;
            end
        end
    end

    // Axis mapping operands: deadzone, sign and denominator
    assign raw       = (i_cmd.start_op == OP_MAPX) ? r_raw_x : r_raw_y;
    assign s_hi      = {1'b0, r_center} + {3'b000, r_dead};
    assign lo        = $signed({2'b00, r_center}) - $signed({4'b0000, r_dead});
    assign den_hi    = W_S'(ADC_FULL_SCALE) - W_S'(r_center) - W_S'(r_dead);
    assign den_hi_ok = !den_hi[W_S-1] && (den_hi != '0);

    always_comb begin
        mag     = '0;
        map_neg = 1'b0;
        map_ok  = 1'b0;
        map_den = W_D'(1);
        if ({1'b0, raw} > s_hi) begin
            mag     = 12'(({1'b0, raw} - s_hi));
            map_ok  = den_hi_ok;
            map_den = den_hi[W_D-1:0];
        end else if (!lo[13] && ($signed({2'b00, raw}) < lo)) begin
            mag     = 12'(lo - $signed({2'b00, raw}));
            map_neg = 1'b1;
            map_ok  = 1'b1;
            map_den = W_D'(lo[11:0]);
        end
    end

    // mag * 127
    assign prod = {mag, 7'd0} - {7'd0, mag};

    // Level divisor, zero treated as one
    always_comb begin
        unique case (r_level)
            LEVEL_ONE: lvl_div = r_div1;
            LEVEL_TWO: lvl_div = r_div2;
            default:   lvl_div = r_div3;
        endcase
        if (lvl_div == 8'd0) begin
            lvl_div = 8'd1;
        end
    end

    // Divider operand select
    always_comb begin
        unique case (i_cmd.start_op)
            OP_MAPX, OP_MAPY: begin
                dividend = map_ok ? {1'b0, prod} : '0;
                divisor  = map_ok ? map_den : W_D'(1);
                cycles   = MAP_DIV_CYC;
            end
            OP_SCLX: begin
                dividend = {1'b0, r_jx_mag, {(W_Q-8){1'b0}}};
                divisor  = W_D'(lvl_div);
                cycles   = SCL_DIV_CYC;
            end
            default: begin
                dividend = {1'b0, r_jy_mag, {(W_Q-8){1'b0}}};
                divisor  = (r_level == LEVEL_THREE) ? W_D'(lvl_div) : W_D'({lvl_div, 2'b00});
                cycles   = SCL_DIV_CYC;
            end
        endcase
    end

    jmd_div #(
        .W_D (W_D)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_cycles   (cycles),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Saturate mapped magnitude to 127
    assign quot_sat = (|quot[W_Q-1:7]) ? AXIS_MAX : quot[6:0];

    // Store divide results; mapping sign kept beside its magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && (i_cmd.start_op == OP_MAPX)) begin
            r_jx_neg <= map_neg;
        end
        if (i_cmd.div_start && (i_cmd.start_op == OP_MAPY)) begin
            r_jy_neg <= map_neg;
        end
        if (i_cmd.store) begin
            case (i_cmd.store_op)
                OP_MAPX: r_jx_mag <= quot_sat;
                OP_MAPY: r_jy_mag <= quot_sat;
                OP_SCLX: r_mx_mag <= quot[6:0];
                default: r_my_mag <= quot[6:0];
            endcase
        end
    end

    // Result formation
    assign mx         = r_jx_neg ? 8'd0 - {1'b0, r_mx_mag} : {1'b0, r_mx_mag};
    assign my         = r_jy_neg ? 8'd0 - {1'b0, r_my_mag} : {1'b0, r_my_mag};
    assign has_motion = (r_mx_mag != 7'd0) || (r_my_mag != 7'd0);
    assign has_click  = r_btn && !r_stepped;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_click <= !has_motion;
            r_out_x     <= has_motion ? mx : 8'd0;
            r_out_y     <= has_motion ? my : 8'd0;
            r_out_level <= r_level;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_left_click = r_out_click;
    assign o_move_x     = $signed(r_out_x);
    assign o_move_y     = $signed(r_out_y);
    assign o_level_now  = r_out_level;

    // Status
    assign o_stat.is_cmd     = r_action;
    assign o_stat.blocked    = blocked;
    assign o_stat.div_done   = div_done;
    assign o_stat.has_result = has_motion || has_click;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

endmodule

// ===== hw/rtl/jmd_ctrl.sv =====
module jmd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jmd_pkg::t_stat i_stat,
    output jmd_pkg::t_cmd  o_cmd
);
    import jmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MAPX,
        S_MAPY,
        S_SCLX,
        S_SCLY,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.start_op  = OP_MAPX;
        o_cmd.store_op  = OP_MAPX;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.is_cmd || i_stat.blocked) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.start_op  = OP_MAPX;
                    n_state         = S_MAPX;
                end
            end
            S_MAPX: begin
                if (i_stat.div_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_op  = OP_MAPX;
                    o_cmd.div_start = 1'b1;
                    o_cmd.start_op  = OP_MAPY;
                    n_state         = S_MAPY;
                end
            end
            S_MAPY: begin
                if (i_stat.div_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_op  = OP_MAPY;
                    o_cmd.div_start = 1'b1;
                    o_cmd.start_op  = OP_SCLX;
                    n_state         = S_SCLX;
                end
            end
            S_SCLX: begin
                if (i_stat.div_done) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.store_op  = OP_SCLX;
                    o_cmd.div_start = 1'b1;
                    o_cmd.start_op  = OP_SCLY;
                    n_state         = S_SCLY;
                end
            end
            S_SCLY: begin
                if (i_stat.div_done) begin
                    o_cmd.store    = 1'b1;
                    o_cmd.store_op = OP_SCLY;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.has_result) begin
                    n_state = S_IDLE;
                end else if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
